// ===== rtl/core/ps2_mouse_packet_decoder_unit_macros.svh =====
// Assertion macros shared by the PS/2 mouse packet decoder RTL.
`ifndef PS2_MOUSE_PACKET_DECODER_UNIT_MACROS_SVH
`define PS2_MOUSE_PACKET_DECODER_UNIT_MACROS_SVH

// Same-cycle implication, switched off during reset.
`define PS2MPD_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ps2mpd: implication check failed");

// Next-cycle implication, switched off during reset.
`define PS2MPD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ps2mpd: next-cycle check failed");

// Next-cycle implication that also holds while reset is asserted.
`define PS2MPD_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("ps2mpd: reset check failed");

`endif

// ===== rtl/core/ps2mpd_pkg.sv =====
// Types and constants of the PS/2 mouse packet decoder.
`default_nettype none

package ps2mpd_pkg;

   localparam logic [7:0] AUX_DATA_MASK       = 8'h20;
   localparam logic [1:0] LAST_BYTE_POS       = 2'd2;
   localparam int         QUEUE_DEPTH_DEFAULT = 2;

   typedef enum logic [1:0] {
      EVENT_MOVE    = 2'd0,
      EVENT_PRESS   = 2'd1,
      EVENT_RELEASE = 2'd2
   } event_kind_type;

   typedef struct packed {
      logic [7:0] status_byte;
      logic [7:0] data_byte;
   } req_payload_type;

   typedef struct packed {
      event_kind_type     event_kind;
      logic signed [7:0]  move_dx;
      logic signed [7:0]  move_dy;
      logic [1:0]         button_number;
      logic               last_event;
   } rsp_payload_type;

   // One completed packet that causes at least one event.
   typedef struct packed {
      logic       has_move;
      logic [7:0] dx;
      logic [7:0] dy;
      logic [2:0] changed;
      logic [2:0] buttons;
   } packet_desc_type;

endpackage

`default_nettype wire

// ===== rtl/core/ps2mpd_front.sv =====
// Front end: byte gathering, packet classification and button tracking.
`default_nettype none

module ps2mpd_front (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_ready,
   input  wire ps2mpd_pkg::req_payload_type req_data,
   input  wire logic                        csr_valid,
   output logic                             csr_ready,
   input  wire logic                        csr_data,
   output logic                             push_valid,
   output ps2mpd_pkg::packet_desc_type      push_data,
   input  wire logic                        queue_full
);

   logic       events_enabled_ff, events_enabled_in;
   logic [1:0] byte_position_ff, byte_position_in;
   logic [2:0] button_bits_ff, button_bits_in;
   logic [7:0] byte0_ff, byte1_ff;
   logic       accept, aux, complete;

   assign req_ready = !queue_full;
   assign csr_ready = 1'b1;
   assign accept    = req_valid && req_ready;
   assign aux       = (req_data.status_byte & ps2mpd_pkg::AUX_DATA_MASK) != 8'd0;
   assign complete  = accept && aux && (byte_position_ff == ps2mpd_pkg::LAST_BYTE_POS);

   always_comb begin
      push_data.dx       = byte1_ff;
      push_data.dy       = 8'(8'd0 - req_data.data_byte);
      push_data.buttons  = byte0_ff[2:0];
      push_data.changed  = byte0_ff[2:0] ^ button_bits_ff;
      push_data.has_move = (byte1_ff != 8'd0) || (req_data.data_byte != 8'd0);
      push_valid = complete && events_enabled_ff
                   && (push_data.has_move || (push_data.changed != 3'd0));
   end

   always_comb begin
      events_enabled_in = events_enabled_ff;
      byte_position_in  = byte_position_ff;
      button_bits_in    = button_bits_ff;
      if (csr_valid && csr_ready) begin
         events_enabled_in = csr_data;
      end
      if (accept && aux) begin
         byte_position_in = complete ? 2'd0 : byte_position_ff + 2'd1;
      end
      // hold the button bits while events are off
      if (complete && events_enabled_ff) begin
         button_bits_in = byte0_ff[2:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         events_enabled_ff <= 1'b1;
         byte_position_ff  <= 2'd0;
         button_bits_ff    <= 3'd0;
      end else begin
         events_enabled_ff <= events_enabled_in;
         byte_position_ff  <= byte_position_in;
         button_bits_ff    <= button_bits_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && aux && (byte_position_ff == 2'd0)) begin
         byte0_ff <= req_data.data_byte;
      end
      if (accept && aux && (byte_position_ff == 2'd1)) begin
         byte1_ff <= req_data.data_byte;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/ps2mpd_queue.sv =====
// Short queue of packet descriptors between front and back end.
`default_nettype none

module ps2mpd_queue #(
   parameter int DEPTH = ps2mpd_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        push_valid,
   input  wire ps2mpd_pkg::packet_desc_type push_data,
   output logic                             full,
   output logic                             pop_valid,
   input  wire logic                        pop_ready,
   output ps2mpd_pkg::packet_desc_type      pop_data
);

   localparam int IndexWidth = $clog2(DEPTH);
   localparam int CountWidth = $clog2(DEPTH + 1);

   ps2mpd_pkg::packet_desc_type entries_ff [DEPTH];
   logic [IndexWidth-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CountWidth-1:0] count_ff, count_in;
   logic                  do_push, do_pop;

   assign full      = count_ff == CountWidth'(DEPTH);
   assign pop_valid = count_ff != '0;
   assign pop_data  = entries_ff[rd_ptr_ff];
   assign do_push   = push_valid && !full;
   assign do_pop    = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == IndexWidth'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == IndexWidth'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/ps2mpd_back.sv =====
// Back end: expands a packet descriptor into events, one per cycle while rsp is not stalled.
`default_nettype none

module ps2mpd_back (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        pop_valid,
   output logic                             pop_ready,
   input  wire ps2mpd_pkg::packet_desc_type pop_data,
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   output ps2mpd_pkg::rsp_payload_type      rsp_data
);

   // pending bit 0 is the move event, bits 1 to 3 the buttons
   logic [3:0]                  pending_ff, pending_in;
   ps2mpd_pkg::packet_desc_type desc_ff;
   logic                        rsp_valid_ff, rsp_valid_in;
   ps2mpd_pkg::rsp_payload_type rsp_data_ff, rsp_data_in;
   logic [3:0]                  pick;
   logic                        out_free, emit, load;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign emit      = out_free && (pending_ff != 4'd0);
   assign pop_ready = pending_ff == 4'd0;
   assign load      = pop_valid && pop_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // lowest pending event goes first
   assign pick = pending_ff & 4'(~pending_ff + 4'd1);

   always_comb begin
      rsp_data_in               = rsp_data_ff;
      rsp_data_in.event_kind    = ps2mpd_pkg::EVENT_MOVE;
      rsp_data_in.move_dx       = 8'sd0;
      rsp_data_in.move_dy       = 8'sd0;
      rsp_data_in.button_number = 2'd0;
      rsp_data_in.last_event    = (pending_ff & ~pick) == 4'd0;
      if (pick[0]) begin
         rsp_data_in.move_dx = desc_ff.dx;
         rsp_data_in.move_dy = desc_ff.dy;
      end else if (pick[1]) begin
         rsp_data_in.button_number = 2'd1;
         rsp_data_in.event_kind    = desc_ff.buttons[0] ? ps2mpd_pkg::EVENT_PRESS
                                                        : ps2mpd_pkg::EVENT_RELEASE;
      end else if (pick[2]) begin
         rsp_data_in.button_number = 2'd2;
         rsp_data_in.event_kind    = desc_ff.buttons[1] ? ps2mpd_pkg::EVENT_PRESS
                                                        : ps2mpd_pkg::EVENT_RELEASE;
      end else begin
         rsp_data_in.button_number = 2'd3;
         rsp_data_in.event_kind    = desc_ff.buttons[2] ? ps2mpd_pkg::EVENT_PRESS
                                                        : ps2mpd_pkg::EVENT_RELEASE;
      end
   end

   always_comb begin
      pending_in   = pending_ff;
      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         pending_in = {pop_data.changed, pop_data.has_move};
      end else if (emit) begin
         pending_in = pending_ff & ~pick;
      end
      if (out_free) begin
         rsp_valid_in = emit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff   <= 4'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pending_ff   <= pending_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         desc_ff <= pop_data;
      end
      if (emit) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/ps2_mouse_packet_decoder_unit.sv =====
// Top level of the PS/2 mouse three-byte packet decoder.
//
//   channel  direction  payload                         transfer when
//   req      in         status_byte, data_byte          req_valid & req_ready
//   rsp      out        event_kind, dx, dy, button, last rsp_valid & rsp_ready
//   csr      in         events_enabled                  csr_valid & csr_ready
//
// A byte is taken every cycle while the descriptor queue has room.
// A packet's first event passes the queue, then the expander, then the output register
// before it shows on rsp; the rest follow one per cycle while rsp is not stalled.
// Between packets the expander emits nothing while it loads the next descriptor.
// Synchronous reset clears position, button bits, queue and output; events start enabled.
// A stalled rsp fills the queue, and req_ready drops only when the queue is full.
`default_nettype none
`include "ps2_mouse_packet_decoder_unit_macros.svh"

module ps2_mouse_packet_decoder_unit #(
   parameter int QUEUE_DEPTH = ps2mpd_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_ready,
   input  wire ps2mpd_pkg::req_payload_type req_data,
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   output ps2mpd_pkg::rsp_payload_type      rsp_data,
   input  wire logic                        csr_valid,
   output logic                             csr_ready,
   input  wire logic                        csr_data
);

   logic                        push_valid, queue_full, pop_valid, pop_ready;
   ps2mpd_pkg::packet_desc_type push_data, pop_data;

   ps2mpd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .push_valid (push_valid),
      .push_data  (push_data),
      .queue_full (queue_full)
   );

   ps2mpd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .full       (queue_full),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   ps2mpd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_data  (pop_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // button events carry no deltas and always name a button
   `PS2MPD_ASSERT_IMPL(a_button_shape, clock, reset,
      rsp_valid && (rsp_data.event_kind != ps2mpd_pkg::EVENT_MOVE),
      (rsp_data.move_dx == 8'sd0) && (rsp_data.move_dy == 8'sd0)
      && (rsp_data.button_number != 2'd0))

   // move events carry no button and a nonzero delta
   `PS2MPD_ASSERT_IMPL(a_move_shape, clock, reset,
      rsp_valid && (rsp_data.event_kind == ps2mpd_pkg::EVENT_MOVE),
      (rsp_data.button_number == 2'd0)
      && ((rsp_data.move_dx != 8'sd0) || (rsp_data.move_dy != 8'sd0)))

   // the rest of a packet follows without a gap
   `PS2MPD_ASSERT_NEXT(a_packet_runs_on, clock, reset,
      rsp_valid && rsp_ready && !rsp_data.last_event,
      rsp_valid)

   `PS2MPD_ASSERT_NEXT_ALWAYS(a_reset_clears_rsp, clock, reset, !rsp_valid)

endmodule

`default_nettype wire
